/* hw/rtl/accel_stillness_timer_defines.svh */
// Assertion macros shared by the stillness timer RTL.
`ifndef ACCEL_STILLNESS_TIMER_DEFINES_SVH
`define ACCEL_STILLNESS_TIMER_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define AST_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define AST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ast_pkg.sv */
// Types, constants and control program of the stillness timer.
`default_nettype none

package ast_pkg;

   // Field widths
   localparam int AXIS_W     = 16;
   localparam int GAIN_W     = 16;
   localparam int REF_W      = 15;
   localparam int TIME_W     = 32;
   localparam int MAG_W      = 32;
   localparam int MIN_W      = 11;
   localparam int SEC_W      = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Shared multiplier: 17 x 17 signed
   localparam int MUL_W  = 17;
   localparam int PROD_W = 2 * MUL_W;
   localparam int CAL_W  = 20;

   localparam int FRAC_SHIFT = 14;
   localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(1 << (FRAC_SHIFT - 1));
   localparam logic signed [CAL_W-1:0] SAT_MAX = CAL_W'(32767);
   localparam logic signed [CAL_W-1:0] SAT_MIN = -CAL_W'(32768);

   // Constant divider, four quotient bits per step
   localparam int DIV_DIGIT_BITS = 4;
   localparam int REM_W          = 10;
   localparam int DIV_CNT_W      = 4;
   localparam logic [REM_W:0] DIVISOR_MS  = (REM_W + 1)'(1000);
   localparam logic [REM_W:0] DIVISOR_SEC = (REM_W + 1)'(60);
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_MS  = DIV_CNT_W'(TIME_W / DIV_DIGIT_BITS);
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SEC = DIV_CNT_W'(16 / DIV_DIGIT_BITS);
   localparam int SEC_SPLIT_W = 16;

   // Register reset values
   localparam logic [GAIN_W-1:0]        GAIN_X_RST   = 16'd15741;
   localparam logic signed [AXIS_W-1:0] OFFSET_X_RST = 16'sd0;
   localparam logic [GAIN_W-1:0]        GAIN_Y_RST   = 16'd15734;
   localparam logic signed [AXIS_W-1:0] OFFSET_Y_RST = 16'sd48;
   localparam logic [GAIN_W-1:0]        GAIN_Z_RST   = 16'd15897;
   localparam logic signed [AXIS_W-1:0] OFFSET_Z_RST = -16'sd646;
   localparam logic [REF_W-1:0]         GRAVITY_RST  = 15'd2509;
   localparam logic [REF_W-1:0]         TOL_RST      = 15'd102;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_X      = 3'd0,
      CSR_OFFSET_X    = 3'd1,
      CSR_GAIN_Y      = 3'd2,
      CSR_OFFSET_Y    = 3'd3,
      CSR_GAIN_Z      = 3'd4,
      CSR_OFFSET_Z    = 3'd5,
      CSR_GRAVITY_REF = 3'd6,
      CSR_TOLERANCE   = 3'd7
   } ast_csr_idx_type;

   typedef enum logic [2:0] {
      MUL_GX  = 3'd0,
      MUL_GY  = 3'd1,
      MUL_GZ  = 3'd2,
      MUL_SQX = 3'd3,
      MUL_SQY = 3'd4,
      MUL_SQZ = 3'd5,
      MUL_HI  = 3'd6,
      MUL_LO  = 3'd7
   } ast_mul_sel_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } ast_axis_type;

   typedef enum logic [1:0] {
      MAG_HOLD = 2'd0,
      MAG_LOAD = 2'd1,
      MAG_ADD  = 2'd2
   } ast_mag_op_type;

   typedef enum logic [1:0] {
      DIV_IDLE     = 2'd0,
      DIV_LOAD_MS  = 2'd1,
      DIV_LOAD_SEC = 2'd2,
      DIV_STEP     = 2'd3
   } ast_div_op_type;

   typedef enum logic [1:0] {
      COND_NEXT     = 2'd0,
      COND_NO_REQ   = 2'd1,
      COND_DIV_MORE = 2'd2,
      COND_OUT_FULL = 2'd3
   } ast_cond_type;

   localparam int STEP_W = 5;

   // Program steps
   localparam logic [STEP_W-1:0] ST_IDLE     = 5'd0;
   localparam logic [STEP_W-1:0] ST_MUL_GX   = 5'd1;
   localparam logic [STEP_W-1:0] ST_CAL_X    = 5'd2;
   localparam logic [STEP_W-1:0] ST_CAL_Y    = 5'd3;
   localparam logic [STEP_W-1:0] ST_CAL_Z    = 5'd4;
   localparam logic [STEP_W-1:0] ST_HI_SQ    = 5'd5;
   localparam logic [STEP_W-1:0] ST_LO_SQ    = 5'd6;
   localparam logic [STEP_W-1:0] ST_MAG_X    = 5'd7;
   localparam logic [STEP_W-1:0] ST_MAG_Y    = 5'd8;
   localparam logic [STEP_W-1:0] ST_MAG_Z    = 5'd9;
   localparam logic [STEP_W-1:0] ST_WINDOW   = 5'd10;
   localparam logic [STEP_W-1:0] ST_TIMER    = 5'd11;
   localparam logic [STEP_W-1:0] ST_DIV_MS   = 5'd12;
   localparam logic [STEP_W-1:0] ST_LOOP_MS  = 5'd13;
   localparam logic [STEP_W-1:0] ST_DIV_SEC  = 5'd14;
   localparam logic [STEP_W-1:0] ST_LOOP_SEC = 5'd15;
   localparam logic [STEP_W-1:0] ST_EMIT     = 5'd16;

   typedef struct packed {
      logic                take;
      logic                mul_en;
      ast_mul_sel_type     mul_sel;
      logic                cal_wr;
      ast_axis_type        cal_axis;
      logic                hi_wr;
      logic                lo_wr;
      ast_mag_op_type      mag_op;
      logic                win_chk;
      logic                tmr_upd;
      ast_div_op_type      div_op;
      logic                emit;
      logic                wrap;
      ast_cond_type        cond;
      logic [STEP_W-1:0]   target;
   } ast_ctl_type;

   typedef struct packed {
      logic req_valid;
      logic out_full;
      logic div_more;
   } ast_sts_type;

   // Control store: one word per program step
   function automatic ast_ctl_type ast_ucode(input logic [STEP_W-1:0] step);
      ast_ctl_type ctl;
      ctl = '0;
      case (step)
         ST_IDLE: begin
            ctl.take   = 1'b1;
            ctl.cond   = COND_NO_REQ;
            ctl.target = ST_IDLE;
         end
         ST_MUL_GX: begin
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MUL_GX;
         end
         ST_CAL_X: begin
            ctl.cal_wr   = 1'b1;
            ctl.cal_axis = AXIS_X;
            ctl.mul_en   = 1'b1;
            ctl.mul_sel  = MUL_GY;
         end
         ST_CAL_Y: begin
            ctl.cal_wr   = 1'b1;
            ctl.cal_axis = AXIS_Y;
            ctl.mul_en   = 1'b1;
            ctl.mul_sel  = MUL_GZ;
         end
         ST_CAL_Z: begin
            ctl.cal_wr   = 1'b1;
            ctl.cal_axis = AXIS_Z;
            ctl.mul_en   = 1'b1;
            ctl.mul_sel  = MUL_HI;
         end
         ST_HI_SQ: begin
            ctl.hi_wr   = 1'b1;
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MUL_LO;
         end
         ST_LO_SQ: begin
            ctl.lo_wr   = 1'b1;
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MUL_SQX;
         end
         ST_MAG_X: begin
            ctl.mag_op  = MAG_LOAD;
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MUL_SQY;
         end
         ST_MAG_Y: begin
            ctl.mag_op  = MAG_ADD;
            ctl.mul_en  = 1'b1;
            ctl.mul_sel = MUL_SQZ;
         end
         ST_MAG_Z:    ctl.mag_op  = MAG_ADD;
         ST_WINDOW:   ctl.win_chk = 1'b1;
         ST_TIMER:    ctl.tmr_upd = 1'b1;
         ST_DIV_MS:   ctl.div_op  = DIV_LOAD_MS;
         ST_LOOP_MS: begin
            ctl.div_op = DIV_STEP;
            ctl.cond   = COND_DIV_MORE;
            ctl.target = ST_LOOP_MS;
         end
         ST_DIV_SEC:  ctl.div_op  = DIV_LOAD_SEC;
         ST_LOOP_SEC: begin
            ctl.div_op = DIV_STEP;
            ctl.cond   = COND_DIV_MORE;
            ctl.target = ST_LOOP_SEC;
         end
         ST_EMIT: begin
            ctl.emit   = 1'b1;
            ctl.wrap   = 1'b1;
            ctl.cond   = COND_OUT_FULL;
            ctl.target = ST_EMIT;
         end
         default: ctl.wrap = 1'b1;
      endcase
      return ctl;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/ast_req_if.sv */
// Sample channel: valid/ready handshake with raw axes and timestamp.
`default_nettype none

interface ast_req_if;
   import ast_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [AXIS_W-1:0] raw_x;
   logic signed [AXIS_W-1:0] raw_y;
   logic signed [AXIS_W-1:0] raw_z;
   logic [TIME_W-1:0]        now_ms;

   modport source (output valid, raw_x, raw_y, raw_z, now_ms, input ready);
   modport sink   (input valid, raw_x, raw_y, raw_z, now_ms, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ast_rsp_if.sv */
// Result channel: valid/ready handshake with calibrated axes and timer fields.
`default_nettype none

interface ast_rsp_if;
   import ast_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [AXIS_W-1:0] cal_x;
   logic signed [AXIS_W-1:0] cal_y;
   logic signed [AXIS_W-1:0] cal_z;
   logic [MAG_W-1:0]         magnitude_sq;
   logic                     moving;
   logic [TIME_W-1:0]        still_ms;
   logic [MIN_W-1:0]         still_minutes;
   logic [SEC_W-1:0]         still_seconds;

   modport source (output valid, cal_x, cal_y, cal_z, magnitude_sq, moving, still_ms,
                   still_minutes, still_seconds, input ready);
   modport sink   (input valid, cal_x, cal_y, cal_z, magnitude_sq, moving, still_ms,
                   still_minutes, still_seconds, output ready);
endinterface

`default_nettype wire

/* hw/rtl/accel_stillness_timer.sv */
// Three-axis stillness timer.
//
// req_if carries one beat per sample: raw_x/raw_y/raw_z (signed Q8.8) and
// the millisecond timestamp now_ms. rsp_if returns exactly one beat per
// sample: calibrated axes, squared magnitude, the moving flag, still time in
// milliseconds and its minutes/seconds split. csr_we/csr_index/csr_wdata
// write the gain, offset, gravity and tolerance registers; write them only
// while no sample is in flight.
//
// Samples are taken one at a time: the next is accepted only once the
// program is back at idle. The control program makes eight passes through
// the single 17x17 multiplier, then 8 + 4 radix-16 steps of the constant
// divider for the seconds split.
//
// Reset: the step counter returns to idle, the registers take their default
// calibration, and the stillness start time clears to zero.
// Stall: the result sits in the output register until taken. The next
// sample is accepted and worked on meanwhile; the program waits at its last
// step only while the previous beat is still unclaimed.
`default_nettype none
`include "accel_stillness_timer_defines.svh"

module accel_stillness_timer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ast_req_if.sink                             req_if,
   ast_rsp_if.source                           rsp_if,
   input  wire logic                           csr_we,
   input  wire logic [ast_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ast_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ast_pkg::*;

   ast_ctl_type        ctl;
   ast_sts_type        sts;
   logic               accept;
   logic               out_full;
   logic               div_more;
   logic [TIME_W-1:0]  duration;
   logic [TIME_W-1:0]  div_quot;
   logic [REM_W-1:0]   div_rem;

   // Ready only at the idle step of the program
   assign req_if.ready = ctl.take;
   assign accept       = req_if.valid && ctl.take;

   assign sts.req_valid = req_if.valid;
   assign sts.out_full  = out_full;
   assign sts.div_more  = div_more;

   ast_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl)
   );

   // Seconds split: milliseconds by 1000, then truncated seconds by 60
   ast_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .op       (ctl.div_op),
      .dividend (duration),
      .quot     (div_quot),
      .rem      (div_rem),
      .more     (div_more)
   );

   ast_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .accept            (accept),
      .raw_x             (req_if.raw_x),
      .raw_y             (req_if.raw_y),
      .raw_z             (req_if.raw_z),
      .now_ms            (req_if.now_ms),
      .div_quot          (div_quot),
      .div_rem           (div_rem),
      .rsp_ready         (rsp_if.ready),
      .out_full          (out_full),
      .duration          (duration),
      .rsp_valid         (rsp_if.valid),
      .rsp_cal_x         (rsp_if.cal_x),
      .rsp_cal_y         (rsp_if.cal_y),
      .rsp_cal_z         (rsp_if.cal_z),
      .rsp_magnitude_sq  (rsp_if.magnitude_sq),
      .rsp_moving        (rsp_if.moving),
      .rsp_still_ms      (rsp_if.still_ms),
      .rsp_still_minutes (rsp_if.still_minutes),
      .rsp_still_seconds (rsp_if.still_seconds)
   );

   // A moving beat restarts the timer, so it must report zero still time
   `AST_ASSERT_HOLDS(a_moving_zero_ms, clock, reset, rsp_if.valid && rsp_if.moving |-> rsp_if.still_ms == 32'd0, "moving beat with non-zero still time")

   // Remainder of the divide by sixty stays below sixty
   `AST_ASSERT_HOLDS(a_seconds_range, clock, reset, rsp_if.valid |-> rsp_if.still_seconds < 6'd60, "still seconds out of range")

   // Drop ready once a sample is taken: one sample in the program at a time
   `AST_ASSERT_NEXT(a_one_in_flight, clock, reset, req_if.valid && req_if.ready, !req_if.ready, "ready held after accepting a sample")

endmodule

`default_nettype wire

/* hw/rtl/ast_sequencer.sv */
// Step counter and control store with conditional jumps.
`default_nettype none

module ast_sequencer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ast_pkg::ast_sts_type sts,
   output      ast_pkg::ast_ctl_type ctl
);
   import ast_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              jump;

   assign ctl = ast_ucode(step_ff);

   always_comb begin
      unique case (ctl.cond)
         COND_NEXT:     jump = 1'b0;
         COND_NO_REQ:   jump = !sts.req_valid;
         COND_DIV_MORE: jump = sts.div_more;
         COND_OUT_FULL: jump = sts.out_full;
      endcase
      if (jump) begin
         step_in = ctl.target;
      end else if (ctl.wrap) begin
         step_in = ST_IDLE;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/ast_divider.sv */
// Divide by a fixed 1000 or 60, four quotient bits per step.
`default_nettype none

module ast_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ast_pkg::ast_div_op_type     op,
   input  wire logic [ast_pkg::TIME_W-1:0]  dividend,
   output      logic [ast_pkg::TIME_W-1:0]  quot,
   output      logic [ast_pkg::REM_W-1:0]   rem,
   output      logic                        more
);
   import ast_pkg::*;

   logic [TIME_W-1:0]    num_ff;
   logic [TIME_W-1:0]    num_in;
   logic [REM_W-1:0]     rem_ff;
   logic [REM_W-1:0]     rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_CNT_W-1:0] cnt_in;
   logic                 sec_ff;
   logic                 sec_in;
   logic [REM_W:0]       divisor;
   logic [REM_W:0]       part;
   logic [TIME_W-1:0]    shift;

   assign divisor = sec_ff ? DIVISOR_SEC : DIVISOR_MS;

   // One radix-16 digit: four shift/compare/subtract rounds
   always_comb begin
      part  = {1'b0, rem_ff};
      shift = num_ff;
      for (int k = 0; k < DIV_DIGIT_BITS; k++) begin
         part  = {part[REM_W-1:0], shift[TIME_W-1]};
         shift = {shift[TIME_W-2:0], 1'b0};
         if (part >= divisor) begin
            part     = part - divisor;
            shift[0] = 1'b1;
         end
      end
   end

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      sec_in = sec_ff;
      unique case (op)
         DIV_IDLE: ;
         DIV_LOAD_MS: begin
            num_in = dividend;
            rem_in = '0;
            cnt_in = DIV_STEPS_MS;
            sec_in = 1'b0;
         end
         DIV_LOAD_SEC: begin
            // keep the low 16 quotient bits, left aligned
            num_in = {num_ff[SEC_SPLIT_W-1:0], {(TIME_W - SEC_SPLIT_W){1'b0}}};
            rem_in = '0;
            cnt_in = DIV_STEPS_SEC;
            sec_in = 1'b1;
         end
         DIV_STEP: begin
            num_in = shift;
            rem_in = part[REM_W-1:0];
            cnt_in = cnt_ff - 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sec_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         sec_ff <= sec_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign quot = num_ff;
   assign rem  = rem_ff;
   assign more = (cnt_ff > DIV_CNT_W'(1));

endmodule

`default_nettype wire

/* hw/rtl/ast_datapath.sv */
// Calibration, magnitude window, stillness timer and result register.
`default_nettype none

module ast_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ast_pkg::ast_ctl_type               ctl,
   input  wire logic                               csr_we,
   input  wire logic [ast_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ast_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                               accept,
   input  wire logic signed [ast_pkg::AXIS_W-1:0]  raw_x,
   input  wire logic signed [ast_pkg::AXIS_W-1:0]  raw_y,
   input  wire logic signed [ast_pkg::AXIS_W-1:0]  raw_z,
   input  wire logic [ast_pkg::TIME_W-1:0]         now_ms,
   input  wire logic [ast_pkg::TIME_W-1:0]         div_quot,
   input  wire logic [ast_pkg::REM_W-1:0]          div_rem,
   input  wire logic                               rsp_ready,
   output      logic                               out_full,
   output      logic [ast_pkg::TIME_W-1:0]         duration,
   output      logic                               rsp_valid,
   output      logic signed [ast_pkg::AXIS_W-1:0]  rsp_cal_x,
   output      logic signed [ast_pkg::AXIS_W-1:0]  rsp_cal_y,
   output      logic signed [ast_pkg::AXIS_W-1:0]  rsp_cal_z,
   output      logic [ast_pkg::MAG_W-1:0]          rsp_magnitude_sq,
   output      logic                               rsp_moving,
   output      logic [ast_pkg::TIME_W-1:0]         rsp_still_ms,
   output      logic [ast_pkg::MIN_W-1:0]          rsp_still_minutes,
   output      logic [ast_pkg::SEC_W-1:0]          rsp_still_seconds
);
   import ast_pkg::*;

   // Configuration registers
   logic [GAIN_W-1:0]        gain_x_ff, gain_y_ff, gain_z_ff;
   logic signed [AXIS_W-1:0] offset_x_ff, offset_y_ff, offset_z_ff;
   logic [REF_W-1:0]         gravity_ff, tol_ff;

   // Sample and working registers
   logic signed [AXIS_W-1:0] raw_x_ff, raw_y_ff, raw_z_ff;
   logic [TIME_W-1:0]        now_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [AXIS_W-1:0] cal_x_ff, cal_y_ff, cal_z_ff;
   logic [MAG_W-1:0]         hi_sq_ff, lo_sq_ff, mag_ff;
   logic                     lo_vld_ff;
   logic                     moving_ff;
   logic                     moving_in;
   logic [TIME_W-1:0]        start_ff, dur_ff;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic [REF_W:0]           win_hi;
   logic [REF_W-1:0]         win_lo;
   logic signed [PROD_W-1:0] rnd_full;
   logic signed [AXIS_W-1:0] cal_off;
   logic signed [CAL_W-1:0]  cal_sum;
   logic signed [AXIS_W-1:0] cal_sat;
   logic                     low_ok;
   logic                     emit_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_x_ff   <= GAIN_X_RST;
         offset_x_ff <= OFFSET_X_RST;
         gain_y_ff   <= GAIN_Y_RST;
         offset_y_ff <= OFFSET_Y_RST;
         gain_z_ff   <= GAIN_Z_RST;
         offset_z_ff <= OFFSET_Z_RST;
         gravity_ff  <= GRAVITY_RST;
         tol_ff      <= TOL_RST;
      end else if (csr_we) begin
         unique case (ast_csr_idx_type'(csr_index))
            CSR_GAIN_X:      gain_x_ff   <= csr_wdata;
            CSR_OFFSET_X:    offset_x_ff <= csr_wdata;
            CSR_GAIN_Y:      gain_y_ff   <= csr_wdata;
            CSR_OFFSET_Y:    offset_y_ff <= csr_wdata;
            CSR_GAIN_Z:      gain_z_ff   <= csr_wdata;
            CSR_OFFSET_Z:    offset_z_ff <= csr_wdata;
            CSR_GRAVITY_REF: gravity_ff  <= csr_wdata[REF_W-1:0];
            CSR_TOLERANCE:   tol_ff      <= csr_wdata[REF_W-1:0];
         endcase
      end
   end

   assign win_hi = {1'b0, gravity_ff} + {1'b0, tol_ff};
   assign win_lo = gravity_ff - tol_ff;

   // Operand select for the shared multiplier
   always_comb begin
      unique case (ctl.mul_sel)
         MUL_GX: begin
            mul_a = {1'b0, gain_x_ff};
            mul_b = {raw_x_ff[AXIS_W-1], raw_x_ff};
         end
         MUL_GY: begin
            mul_a = {1'b0, gain_y_ff};
            mul_b = {raw_y_ff[AXIS_W-1], raw_y_ff};
         end
         MUL_GZ: begin
            mul_a = {1'b0, gain_z_ff};
            mul_b = {raw_z_ff[AXIS_W-1], raw_z_ff};
         end
         MUL_SQX: begin
            mul_a = {cal_x_ff[AXIS_W-1], cal_x_ff};
            mul_b = mul_a;
         end
         MUL_SQY: begin
            mul_a = {cal_y_ff[AXIS_W-1], cal_y_ff};
            mul_b = mul_a;
         end
         MUL_SQZ: begin
            mul_a = {cal_z_ff[AXIS_W-1], cal_z_ff};
            mul_b = mul_a;
         end
         MUL_HI: begin
            mul_a = {1'b0, win_hi};
            mul_b = mul_a;
         end
         MUL_LO: begin
            mul_a = {2'b00, win_lo};
            mul_b = mul_a;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Round Q10.22 to Q8.8 half up, add offset, saturate
   assign rnd_full = (prod_ff + RND_BIAS) >>> FRAC_SHIFT;

   always_comb begin
      case (ctl.cal_axis)
         AXIS_X:  cal_off = offset_x_ff;
         AXIS_Y:  cal_off = offset_y_ff;
         AXIS_Z:  cal_off = offset_z_ff;
         default: cal_off = offset_x_ff;
      endcase
   end

   assign cal_sum = signed'(rnd_full[CAL_W-1:0])
                  + signed'({{(CAL_W - AXIS_W){cal_off[AXIS_W-1]}}, cal_off});

   always_comb begin
      priority if (cal_sum > SAT_MAX) begin
         cal_sat = SAT_MAX[AXIS_W-1:0];
      end else if (cal_sum < SAT_MIN) begin
         cal_sat = SAT_MIN[AXIS_W-1:0];
      end else begin
         cal_sat = cal_sum[AXIS_W-1:0];
      end
   end

   // Strictly inside the window; an empty lower bound always passes
   assign low_ok    = !lo_vld_ff || (mag_ff > lo_sq_ff);
   assign moving_in = !(low_ok && (mag_ff < hi_sq_ff));

   assign out_full  = rsp_valid && !rsp_ready;
   assign emit_fire = ctl.emit && !out_full;
   assign duration  = dur_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         raw_x_ff <= raw_x;
         raw_y_ff <= raw_y;
         raw_z_ff <= raw_z;
         now_ff   <= now_ms;
      end
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.cal_wr) begin
         case (ctl.cal_axis)
            AXIS_X:  cal_x_ff <= cal_sat;
            AXIS_Y:  cal_y_ff <= cal_sat;
            AXIS_Z:  cal_z_ff <= cal_sat;
            default: ;
         endcase
      end
      if (ctl.hi_wr) begin
         hi_sq_ff <= prod_ff[MAG_W-1:0];
      end
      if (ctl.lo_wr) begin
         lo_sq_ff  <= prod_ff[MAG_W-1:0];
         lo_vld_ff <= (gravity_ff >= tol_ff);
      end
      case (ctl.mag_op)
         MAG_LOAD: mag_ff <= prod_ff[MAG_W-1:0];
         MAG_ADD:  mag_ff <= mag_ff + prod_ff[MAG_W-1:0];
         default:  ;
      endcase
      if (ctl.win_chk) begin
         moving_ff <= moving_in;
      end
      if (emit_fire) begin
         rsp_cal_x         <= cal_x_ff;
         rsp_cal_y         <= cal_y_ff;
         rsp_cal_z         <= cal_z_ff;
         rsp_magnitude_sq  <= mag_ff;
         rsp_moving        <= moving_ff;
         rsp_still_ms      <= dur_ff;
         rsp_still_minutes <= div_quot[MIN_W-1:0];
         rsp_still_seconds <= div_rem[SEC_W-1:0];
      end
   end

   // Stillness timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         dur_ff   <= '0;
      end else if (ctl.tmr_upd) begin
         if (moving_ff) begin
            start_ff <= now_ff;
            dur_ff   <= '0;
         end else begin
            dur_ff <= now_ff - start_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

endmodule

`default_nettype wire
